@@ src/gfb_pkg.sv @@
// Shared types, constants and helper functions of the grid feature bucketing block.
package gfb_pkg;

  localparam int CELL_SIZE     = 32;
  localparam int MAX_GRID_COLS = 64;
  localparam int MAX_GRID_ROWS = 64;
  localparam int TABLE_DEPTH   = 256;

  localparam int COORD_W = 12;
  localparam int RESP_W  = 16;
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 13;

  localparam int ROW_W = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int COL_W = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Cell coordinate by reciprocal multiplication; one correction step is enough.
  localparam int DIV_SHIFT = 20;
  localparam int RECIP     = (1 << DIV_SHIFT) / CELL_SIZE;
  localparam int PROD_W    = 32;
  localparam int REM_W     = 20;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_MARK   = 2'd1;
  localparam logic [1:0] FN_INSERT = 2'd2;
  localparam logic [1:0] FN_POP    = 2'd3;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [RESP_W-1:0]  resp;
  } kp_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } tbl_ctl_t;

  typedef struct packed {
    logic             clr;
    logic             rd;
    logic             mark;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } occ_req_t;

  function automatic logic [COORD_W-1:0] cell_coord(input logic [COORD_W-1:0] v);
    logic [PROD_W-1:0]  prod;
    logic [COORD_W-1:0] q0;
    logic [REM_W-1:0]   rem;
    prod = PROD_W'(v) * PROD_W'(RECIP);
    q0   = prod[DIV_SHIFT +: COORD_W];
    rem  = REM_W'(v) - REM_W'(q0) * REM_W'(CELL_SIZE);
    if (rem >= REM_W'(CELL_SIZE)) begin
      q0 = q0 + COORD_W'(1);
    end
    return q0;
  endfunction

  function automatic logic point_inside(input logic [COORD_W-1:0] cx,
                                        input logic [COORD_W-1:0] cy,
                                        input logic [CFG_W-1:0]   cols,
                                        input logic [CFG_W-1:0]   rows);
    logic [COORD_W-1:0] col_lim;
    logic [COORD_W-1:0] row_lim;
    col_lim = COORD_W'(cols);
    row_lim = COORD_W'(rows);
    if (col_lim > COORD_W'(MAX_GRID_COLS)) begin
      col_lim = COORD_W'(MAX_GRID_COLS);
    end
    if (row_lim > COORD_W'(MAX_GRID_ROWS)) begin
      row_lim = COORD_W'(MAX_GRID_ROWS);
    end
    return (cx < col_lim) && (cy < row_lim);
  endfunction

endpackage

@@ src/gfb_cell.sv @@
// One slot of the sorted keypoint table, exchanging entries with its two neighbors.
module gfb_cell
  import gfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tbl_ctl_t ctl,
  input  kp_t      new_ent,
  input  kp_t      prev_ent,
  input  logic     prev_valid,
  input  logic     prev_go,
  input  kp_t      next_ent,
  input  logic     next_valid,
  output kp_t      ent,
  output logic     valid,
  output logic     go
);

  // The new keypoint belongs at or before this slot when it is strictly stronger
  // or the slot is empty, so equal responses keep their arrival order.
  assign go = ctl.ins && (!valid || (new_ent.resp > ent.resp));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= next_valid;
    end else if (go) begin
      valid <= prev_go ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      ent <= next_ent;
    end else if (go) begin
      ent <= prev_go ? prev_ent : new_ent;
    end
  end

endmodule

@@ src/gfb_table.sv @@
// Sorted keypoint table built as a chain of slots, strongest response at the head.
module gfb_table
  import gfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tbl_ctl_t ctl,
  input  kp_t      new_ent,
  output kp_t      head_ent,
  output logic     head_valid
);

  // Index i+1 holds slot i; the two ends are tied off as empty.
  kp_t  chain_ent   [TABLE_DEPTH+2];
  logic chain_valid [TABLE_DEPTH+2];
  logic chain_go    [TABLE_DEPTH+1];

  assign chain_ent[0]               = '0;
  assign chain_valid[0]             = 1'b0;
  assign chain_go[0]                = 1'b0;
  assign chain_ent[TABLE_DEPTH+1]   = '0;
  assign chain_valid[TABLE_DEPTH+1] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
    gfb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_ent    (new_ent),
      .prev_ent   (chain_ent[i]),
      .prev_valid (chain_valid[i]),
      .prev_go    (chain_go[i]),
      .next_ent   (chain_ent[i+2]),
      .next_valid (chain_valid[i+2]),
      .ent        (chain_ent[i+1]),
      .valid      (chain_valid[i+1]),
      .go         (chain_go[i+1])
    );
  end

  assign head_ent   = chain_ent[1];
  assign head_valid = chain_valid[1];

endmodule

@@ src/gfb_occ.sv @@
// Grid occupancy bitmap: one memory row per cell row, cleared by a row sweep.
module gfb_occ
  import gfb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  occ_req_t                 req,
  output logic [MAX_GRID_COLS-1:0] rd_data,
  output logic                     sweeping
);

  logic [MAX_GRID_COLS-1:0] mem [MAX_GRID_ROWS];
  logic [ROW_W-1:0]         sweep_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_row <= '0;
    end else if (req.clr) begin
      sweeping  <= 1'b1;
      sweep_row <= '0;
    end else if (sweeping) begin
      if (sweep_row == ROW_W'(MAX_GRID_ROWS - 1)) begin
        sweeping <= 1'b0;
      end
      sweep_row <= sweep_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[sweep_row] <= '0;
    end else if (req.mark) begin
      mem[req.row][req.col] <= 1'b1;
    end
    if (req.rd) begin
      rd_data <= mem[req.row];
    end
  end

endmodule

@@ src/grid_feature_bucketing.sv @@
// Clear, mark and insert: one cycle each, result strobe one cycle after the transfer.
// Pop: one cycle, or two when the popped point lies in the grid (registered bitmap read).
// Clear also sweeps the bitmap, one row per cycle: busy for MAX_GRID_ROWS cycles after.
// Reset runs the same sweep, so busy stays high for MAX_GRID_ROWS cycles after reset.
// Results are shown for one cycle on done; the receiver cannot stall them.
module grid_feature_bucketing
  import gfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  logic [RESP_W-1:0]  response,
  output logic               done,
  output logic [COORD_W-1:0] pop_x,
  output logic [COORD_W-1:0] pop_y,
  output logic               accepted,
  output logic               empty_res,
  output logic               outside,
  output logic [COUNT_W-1:0] new_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_TEST = 1'b1;

  logic [0:0]               state;
  logic [CFG_W-1:0]         grid_cols;
  logic [CFG_W-1:0]         grid_rows;
  logic [COUNT_W-1:0]       count;
  logic [ROW_W-1:0]         test_row;
  logic [COL_W-1:0]         test_col;
  logic                     accept;
  logic                     sweeping;
  logic [COORD_W-1:0]       in_cx;
  logic [COORD_W-1:0]       in_cy;
  logic                     in_inside;
  logic [COORD_W-1:0]       head_cx;
  logic [COORD_W-1:0]       head_cy;
  logic                     head_inside;
  kp_t                      head_ent;
  logic                     head_valid;
  kp_t                      new_ent;
  tbl_ctl_t                 tbl_ctl;
  occ_req_t                 occ_req;
  logic [MAX_GRID_COLS-1:0] occ_row;
  logic                     cell_taken;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GRID_ROWS) ? 32'(grid_rows) : 32'(grid_cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= CFG_W'(40);
      grid_rows <= CFG_W'(12);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_GRID_ROWS) begin
        grid_rows <= pwdata[CFG_W-1:0];
      end else begin
        grid_cols <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign busy   = (state != ST_IDLE) || sweeping;
  assign accept = start && !busy;

  assign in_cx       = cell_coord(x);
  assign in_cy       = cell_coord(y);
  assign in_inside   = point_inside(in_cx, in_cy, grid_cols, grid_rows);
  assign head_cx     = cell_coord(head_ent.x);
  assign head_cy     = cell_coord(head_ent.y);
  assign head_inside = point_inside(head_cx, head_cy, grid_cols, grid_rows);

  assign new_ent.x    = x;
  assign new_ent.y    = y;
  assign new_ent.resp = response;

  assign tbl_ctl.clr = accept && (func == FN_CLEAR);
  assign tbl_ctl.ins = accept && (func == FN_INSERT) && in_inside;
  assign tbl_ctl.pop = accept && (func == FN_POP) && head_valid;

  gfb_table u_table (
    .clk        (clk),
    .rst        (rst),
    .ctl        (tbl_ctl),
    .new_ent    (new_ent),
    .head_ent   (head_ent),
    .head_valid (head_valid)
  );

  assign cell_taken = occ_row[test_col];

  always_comb begin
    occ_req.clr  = accept && (func == FN_CLEAR);
    occ_req.rd   = accept && (func == FN_POP) && head_valid && head_inside;
    occ_req.mark = 1'b0;
    occ_req.row  = in_cy[ROW_W-1:0];
    occ_req.col  = in_cx[COL_W-1:0];
    if (state == ST_TEST) begin
      occ_req.mark = !cell_taken;
      occ_req.row  = test_row;
      occ_req.col  = test_col;
    end else if (func == FN_POP) begin
      occ_req.row = head_cy[ROW_W-1:0];
      occ_req.col = head_cx[COL_W-1:0];
    end else begin
      occ_req.mark = accept && (func == FN_MARK) && in_inside;
    end
  end

  gfb_occ u_occ (
    .clk      (clk),
    .rst      (rst),
    .req      (occ_req),
    .rd_data  (occ_row),
    .sweeping (sweeping)
  );

  assign new_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pop_x     <= '0;
            pop_y     <= '0;
            accepted  <= 1'b0;
            empty_res <= 1'b0;
            outside   <= 1'b0;
            done      <= 1'b1;
            unique case (func)
              FN_CLEAR: begin
                count <= '0;
              end
              FN_MARK, FN_INSERT: begin
                outside <= !in_inside;
              end
              FN_POP: begin
                if (!head_valid) begin
                  empty_res <= 1'b1;
                end else begin
                  pop_x   <= head_ent.x;
                  pop_y   <= head_ent.y;
                  outside <= !head_inside;
                  if (head_inside) begin
                    // The result waits for the bitmap row read.
                    done     <= 1'b0;
                    state    <= ST_TEST;
                    test_row <= head_cy[ROW_W-1:0];
                    test_col <= head_cx[COL_W-1:0];
                  end
                end
              end
            endcase
          end
        end
        ST_TEST: begin
          done     <= 1'b1;
          accepted <= !cell_taken;
          if (!cell_taken && (count != COUNT_MAX)) begin
            count <= count + COUNT_W'(1);
          end
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
